@@ src/fct_pkg.sv @@
// Shared types, constants and helpers for the frustum cull test pipeline.
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int NUM_AXES    = 3;
  localparam int NORM_W      = 16;
  localparam int NORMAL_FRAC = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int PLANE_W     = 64;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_BOX   = 1'b1;

  typedef struct packed {
    logic [NORM_W-1:0] d;
    logic [NORM_W-1:0] nz;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nx;
  } plane_t;

  typedef plane_t [NUM_PLANES-1:0] plane_set_t;

  function automatic logic [NORM_W-1:0] plane_normal(plane_t pl, logic [1:0] axis);
    logic [NORM_W-1:0] n;
    case (axis)
      2'd0:    n = pl.nx;
      2'd1:    n = pl.ny;
      default: n = pl.nz;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ src/fct_vertex.sv @@
// Vertex select stage: picks the tested corner of the box for each plane.
`timescale 1ns / 1ps
`default_nettype none
module fct_vertex
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire plane_set_t             planes,
  input  wire logic                   up_valid,
  output logic                        up_ready,
  input  wire logic                   op,
  input  wire logic [COORD_WIDTH-1:0] x_min,
  input  wire logic [COORD_WIDTH-1:0] y_min,
  input  wire logic [COORD_WIDTH-1:0] z_min,
  input  wire logic [COORD_WIDTH-1:0] x_max,
  input  wire logic [COORD_WIDTH-1:0] y_max,
  input  wire logic [COORD_WIDTH-1:0] z_max,
  output logic                        dn_valid,
  input  wire logic                   dn_ready,
  output logic [NUM_PLANES-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] vert
);

  logic                                                 valid_r;
  logic [NUM_PLANES-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] vert_r;
  logic [NUM_PLANES-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] vert_nxt;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 lo;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 hi;
  logic [NORM_W-1:0]                                    n_sel;
  logic                                                 take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;
  assign lo       = {z_min, y_min, x_min};
  assign hi       = {z_max, y_max, x_max};

  always_comb begin
    n_sel = '0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        n_sel = plane_normal(planes[i], 2'(a));
        if (op == OP_BOX && !n_sel[NORM_W-1]) begin
          vert_nxt[i][a] = hi[a];
        end else begin
          vert_nxt[i][a] = lo[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vert_r <= vert_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign vert     = vert_r;

endmodule
`default_nettype wire

@@ src/fct_plane_dot.sv @@
// Signed distance stages: per-axis products, then the sum with the plane offset.
`timescale 1ns / 1ps
`default_nettype none
module fct_plane_dot
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire plane_set_t planes,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire logic [NUM_PLANES-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] vert,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output logic [NUM_PLANES-1:0] dist_neg
);

  localparam int PROD_W = COORD_WIDTH + NORM_W;
  localparam int SUM_W  = (PROD_W + 2 > 31) ? PROD_W + 2 : 31;
  localparam int D_W    = NORM_W + NORMAL_FRAC;

  logic                                            prod_valid_r;
  logic                                            sum_valid_r;
  logic                                            prod_ready;
  logic                                            sum_ready;
  logic [NUM_PLANES-1:0][NUM_AXES-1:0][PROD_W-1:0] prod_r;
  logic [NUM_PLANES-1:0][NUM_AXES-1:0][PROD_W-1:0] prod_nxt;
  logic [NUM_PLANES-1:0][SUM_W-1:0]                sum_r;
  logic [NUM_PLANES-1:0][SUM_W-1:0]                sum_nxt;
  logic [NUM_PLANES-1:0][SUM_W-1:0]                d_ext;

  assign sum_ready  = !sum_valid_r || dn_ready;
  assign prod_ready = !prod_valid_r || sum_ready;
  assign up_ready   = prod_ready;

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_nxt[i][a] = $signed(vert[i][a]) * $signed(plane_normal(planes[i], 2'(a)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      d_ext[i] = {{(SUM_W-D_W){planes[i].d[NORM_W-1]}}, planes[i].d, {NORMAL_FRAC{1'b0}}};
      sum_nxt[i] = {{(SUM_W-PROD_W){prod_r[i][0][PROD_W-1]}}, prod_r[i][0]}
                 + {{(SUM_W-PROD_W){prod_r[i][1][PROD_W-1]}}, prod_r[i][1]}
                 + {{(SUM_W-PROD_W){prod_r[i][2][PROD_W-1]}}, prod_r[i][2]}
                 + d_ext[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_r <= up_valid;
      end
      if (sum_ready) begin
        sum_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && prod_ready) begin
      prod_r <= prod_nxt;
    end
    if (prod_valid_r && sum_ready) begin
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      dist_neg[i] = sum_r[i][SUM_W-1];
    end
  end

  assign dn_valid = sum_valid_r;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !up_ready |-> (prod_valid_r && sum_valid_r && !dn_ready))
    else $error("upstream stalled while a stage is free");

  a_sum_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_valid_r && sum_ready) |=> sum_valid_r)
    else $error("product beat lost on its way to the sum stage");

endmodule
`default_nettype wire

@@ src/frustum_cull_test.sv @@
// Throughput: one beat per cycle; stages hold in place while out_ready is low.
// Path: vertex select, products, offset sum, sign check into the output register.
// Reset: synchronous active-low rst_n clears all valid bits and sets every plane
// to zero, which makes every test visible until the planes are written.
`timescale 1ns / 1ps
`default_nettype none
module frustum_cull_test
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [PLANE_W-1:0]     cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_op,
  input  wire logic [COORD_WIDTH-1:0] in_x_min,
  input  wire logic [COORD_WIDTH-1:0] in_y_min,
  input  wire logic [COORD_WIDTH-1:0] in_z_min,
  input  wire logic [COORD_WIDTH-1:0] in_x_max,
  input  wire logic [COORD_WIDTH-1:0] in_y_max,
  input  wire logic [COORD_WIDTH-1:0] in_z_max,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_visible
);

  plane_set_t                                           planes_r;
  logic                                                 v_valid;
  logic                                                 v_ready;
  logic [NUM_PLANES-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] vert;
  logic                                                 s_valid;
  logic                                                 s_ready;
  logic [NUM_PLANES-1:0]                                dist_neg;
  logic                                                 out_valid_r;
  logic                                                 visible_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          planes_r[i] <= cfg_data;
        end
      end
    end
  end

  fct_vertex #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_vertex (
    .clk      (clk),
    .rst_n    (rst_n),
    .planes   (planes_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .op       (in_op),
    .x_min    (in_x_min),
    .y_min    (in_y_min),
    .z_min    (in_z_min),
    .x_max    (in_x_max),
    .y_max    (in_y_max),
    .z_max    (in_z_max),
    .dn_valid (v_valid),
    .dn_ready (v_ready),
    .vert     (vert)
  );

  fct_plane_dot #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_plane_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .planes   (planes_r),
    .up_valid (v_valid),
    .up_ready (v_ready),
    .vert     (vert),
    .dn_valid (s_valid),
    .dn_ready (s_ready),
    .dist_neg (dist_neg)
  );

  assign s_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_ready) begin
      out_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      visible_r <= ~|dist_neg;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid set out of reset");

  a_blocked_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_valid && s_valid && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid && s_ready) |=> out_valid_r)
    else $error("sum beat dropped before the output register");

endmodule
`default_nettype wire
